FILE: hw/rtl/lfpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants for the line follower steering block
// Sizes, register codes, modes, sequencer states and front/back link types.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int NUM_SENSORS  = 12;
  localparam int SAMPLE_MAX   = 1023;
  localparam int MARK_SENSORS = 9;
  localparam int POS_WEIGHT   = 1000;

  localparam int SMP_W  = 10;
  localparam int PAT_W  = 9;
  localparam int DRV_W  = 12;
  localparam int SIDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int CNT_W  = $clog2(NUM_SENSORS + 1);
  localparam int SMP_TOP = (SAMPLE_MAX < 1023) ? SAMPLE_MAX : 1023;
  localparam int WGT_W  = $clog2(NUM_SENSORS * POS_WEIGHT + 1);
  localparam int SUM_W  =
    $clog2(POS_WEIGHT * SMP_TOP * (NUM_SENSORS * (NUM_SENSORS + 1) / 2) + 1);
  localparam int DIVR_W = $clog2(NUM_SENSORS * SMP_TOP + 1);
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int CEN_W  = WGT_W;
  localparam int RUN_W  = $clog2(MARK_SENSORS + 1);
  localparam int ACC_W  = 35;

  typedef enum logic [2:0] {
    CFG_MAX_SPEED = 3'd0,
    CFG_CRUISE    = 3'd1,
    CFG_SETPOINT  = 3'd2,
    CFG_VOTE_LIM  = 3'd3,
    CFG_GAIN_P    = 3'd4,
    CFG_GAIN_D    = 3'd5,
    CFG_SAFETY    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_CENTRE = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    B_IDLE, B_VOTE, B_MODE, B_WALK, B_DSTART, B_DIV, B_PD, B_MULP, B_MULD, B_DRIVE
  } back_state_e;

  typedef struct packed {
    logic [11:0] max_speed;
    logic [11:0] cruise_speed;
    logic [13:0] center_setpoint;
    logic [7:0]  vote_limit;
    logic [15:0] gain_p;
    logic [15:0] gain_d;
    logic        safety_mode;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [PAT_W-1:0] mark;
  } job_t;

  typedef struct packed {
    logic              pop;
    logic              busy;
    logic [SIDX_W-1:0] rd_idx;
  } back_ctl_t;

  function automatic logic [WGT_W-1:0] weight(input logic [SIDX_W-1:0] idx);
    return WGT_W'((int'(idx) + 1) * POS_WEIGHT);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lfpd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_front: sample intake
// Stores one frame of samples, latches the mark pattern and queues one job.
// ----------------------------------------------------------------------------
module lfpd_front import lfpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [SMP_W-1:0] front_value_i,
  input  logic [PAT_W-1:0] mark_pattern_i,
  input  logic             frame_end_i,
  input  back_ctl_t        ctl_i,
  output job_t             job_o,
  output logic [SMP_W-1:0] rd_data_o
);

  logic [SMP_W-1:0] store_q [NUM_SENSORS];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PAT_W-1:0] mark_q, mark_d;
  job_t             job_q, job_d;
  logic             accept;
  logic [SMP_W-1:0] smp;
  logic [PAT_W-1:0] mark_sel;

  assign in_stall_o = job_q.valid | ctl_i.busy;
  assign accept     = in_valid_i & ~in_stall_o;
  assign smp        = (int'(front_value_i) > SMP_TOP) ? SMP_W'(SMP_TOP) : front_value_i;
  assign mark_sel   = (cnt_q == '0) ? mark_pattern_i : mark_q;
  assign job_o      = job_q;
  assign rd_data_o  = store_q[ctl_i.rd_idx];

  always_comb begin
    cnt_d  = cnt_q;
    mark_d = mark_q;
    job_d  = job_q;
    if (ctl_i.pop) begin
      job_d.valid = 1'b0;
    end
    if (accept) begin
      mark_d = mark_sel;
      if (cnt_q < CNT_W'(NUM_SENSORS)) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (frame_end_i) begin
        cnt_d = '0;
        job_d = '{valid: 1'b1, mark: mark_sel};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mark_q <= '0;
      job_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      mark_q <= mark_d;
      job_q  <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cnt_q < CNT_W'(NUM_SENSORS)) begin
      store_q[cnt_q[SIDX_W-1:0]] <= smp;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lfpd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfpd_back: frame evaluation sequencer
// Votes on the mark pattern, walks the centroid, divides, runs PD, clamps.
// ----------------------------------------------------------------------------
module lfpd_back import lfpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  job_t             job_i,
  output back_ctl_t        ctl_o,
  input  logic [SMP_W-1:0] rd_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DRV_W-1:0] left_drive_o,
  output logic [DRV_W-1:0] right_drive_o,
  output logic [1:0]       track_mode_o,
  output logic             line_lost_o,
  output logic [3:0]       transitions_o
);

  back_state_e state_q, state_d;
  logic [7:0]  vc_q, vc_d, vl_q, vl_d, vr_q, vr_d;
  mode_e       mode_q, mode_d;
  logic [MARK_SENSORS-1:0] mark_q, mark_d;
  logic [3:0]  trans_q, trans_d;
  logic [SIDX_W-1:0] k_q, k_d;
  logic        peak_q, peak_d;
  logic [SUM_W-1:0]  sum_q, sum_d, dvd_q, dvd_d, dvd_n;
  logic [DIVR_W-1:0] div_q, div_d, rem_q, rem_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [CEN_W-1:0]  center_q, center_d;
  logic signed [15:0] prev_q, prev_d, prop_q, prop_d, prop_n;
  logic signed [16:0] deriv_q, deriv_d;
  logic        lost_q, lost_d;
  logic signed [31:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d, corr;
  logic        ov_q, ov_d;
  logic [DRV_W-1:0] ld_q, ld_d, rd_q, rd_d;
  logic [1:0]  tm_q, tm_d;
  logic        lo_q, lo_d;
  logic [3:0]  to_q, to_d;

  logic [MARK_SENSORS-2:0] diff;
  logic [3:0]        trans_n;
  logic [RUN_W-1:0]  wr, wl;
  logic              vote_c, vote_l, vote_r;
  logic [SIDX_W-1:0] idx;
  logic              peak_n, stop;
  logic [WGT_W+SMP_W-1:0] term;
  logic signed [32:0] dprod;
  logic [DIVR_W:0]   rem_sh, rem_sub;
  logic              ge;
  logic signed [13:0] floor_v;
  logic signed [ACC_W:0] lv, rv;

  function automatic logic [7:0] vote_up(input logic [7:0] v, input logic [7:0] lim);
    return (v <= lim && v != 8'hFF) ? v + 8'd1 : v;
  endfunction

  function automatic logic [7:0] vote_dn(input logic [7:0] v);
    return (v != 8'd0) ? v - 8'd1 : v;
  endfunction

  function automatic logic [DRV_W-1:0] clamp(input logic signed [ACC_W:0] v,
                                             input logic signed [13:0] lo,
                                             input logic [DRV_W-1:0] hi);
    logic signed [ACC_W:0] r;
    r = v;
    if (v > $signed({{(ACC_W-DRV_W){1'b0}}, 1'b0, hi})) begin
      r = $signed({{(ACC_W-DRV_W){1'b0}}, 1'b0, hi});
    end else if (v < (ACC_W+1)'(lo)) begin
      r = (ACC_W+1)'(lo);
    end
    return r[DRV_W-1:0];
  endfunction

  // mark pattern analysis
  always_comb begin
    for (int i = 1; i < MARK_SENSORS; i++) begin
      diff[i-1] = mark_q[i] ^ mark_q[i-1];
    end
    trans_n = 4'($countones(diff));
    wr = RUN_W'(MARK_SENSORS);
    for (int i = 0; i < MARK_SENSORS; i++) begin
      if (mark_q[i]) wr = RUN_W'(MARK_SENSORS - 1 - i);
    end
    wl = RUN_W'(MARK_SENSORS);
    for (int i = MARK_SENSORS - 1; i >= 0; i--) begin
      if (mark_q[i]) wl = RUN_W'(i);
    end
    vote_c = 1'b0;
    vote_l = 1'b0;
    vote_r = 1'b0;
    if (trans_n == 4'd3) begin
      if (wr != '0) vote_l = 1'b1;
      else vote_r = 1'b1;
    end else if (trans_n == 4'd4) begin
      if (wr != '0) begin
        if ((RUN_W+1)'(wr) > (RUN_W+1)'(wl) + 1'b1) vote_l = 1'b1;
        else if ((RUN_W+1)'(wl) > (RUN_W+1)'(wr) + 1'b1) vote_r = 1'b1;
      end else begin
        vote_c = 1'b1;
      end
    end else if (trans_n >= 4'd5 && trans_n <= 4'd7) begin
      vote_c = 1'b1;
    end
  end

  assign idx    = (mode_q == MODE_RIGHT) ? SIDX_W'(NUM_SENSORS - 1) - k_q : k_q;
  assign peak_n = peak_q | (rd_data_i != '0);
  assign stop   = (mode_q != MODE_CENTRE) && peak_n && (rd_data_i == '0);
  assign term   = weight(idx) * rd_data_i;

  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign dvd_n   = {dvd_q[SUM_W-2:0], ge};

  assign prop_n  = (center_q == '0) ? prev_q
                 : $signed(16'(center_q)) - $signed(16'(cfg_i.center_setpoint));

  assign dprod   = deriv_q * $signed(cfg_i.gain_d);

  assign corr    = (acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0))) >>> 8;
  assign floor_v = ({1'b0, cfg_i.max_speed} >= {1'b0, cfg_i.cruise_speed})
                 ? $signed(14'({1'b0, cfg_i.max_speed} - {1'b0, cfg_i.cruise_speed}))
                 : 14'sd0;
  assign lv      = (ACC_W+1)'(floor_v) - (ACC_W+1)'(corr);
  assign rv      = (ACC_W+1)'(floor_v) + (ACC_W+1)'(corr);

  always_comb begin
    state_d  = state_q;
    vc_d = vc_q; vl_d = vl_q; vr_d = vr_q;
    mode_d   = mode_q;
    mark_d   = mark_q;
    trans_d  = trans_q;
    k_d      = k_q;
    peak_d   = peak_q;
    sum_d    = sum_q;
    div_d    = div_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    center_d = center_q;
    prev_d   = prev_q;
    prop_d   = prop_q;
    deriv_d  = deriv_q;
    lost_d   = lost_q;
    prod_d   = prod_q;
    acc_d    = acc_q;
    ov_d     = ov_q & out_stall_i;
    ld_d = ld_q; rd_d = rd_q; tm_d = tm_q; lo_d = lo_q; to_d = to_q;
    ctl_o.pop    = 1'b0;
    ctl_o.busy   = (state_q != B_IDLE);
    ctl_o.rd_idx = idx;
    unique case (state_q)
      B_IDLE: begin
        if (job_i.valid) begin
          ctl_o.pop = 1'b1;
          mark_d    = MARK_SENSORS'(job_i.mark);
          state_d   = B_VOTE;
        end
      end
      B_VOTE: begin
        trans_d = trans_n;
        if (vote_c) begin
          vc_d = vote_up(vc_q, cfg_i.vote_limit);
          vl_d = vote_dn(vl_q);
          vr_d = vote_dn(vr_q);
        end else if (vote_l) begin
          vl_d = vote_up(vl_q, cfg_i.vote_limit);
          vc_d = vote_dn(vc_q);
          vr_d = vote_dn(vr_q);
        end else if (vote_r) begin
          vr_d = vote_up(vr_q, cfg_i.vote_limit);
          vc_d = vote_dn(vc_q);
          vl_d = vote_dn(vl_q);
        end
        state_d = B_MODE;
      end
      B_MODE: begin
        if (vc_q > vl_q && vc_q > vr_q) mode_d = MODE_CENTRE;
        else if (vl_q > vr_q) mode_d = MODE_LEFT;
        else if (vl_q < vr_q) mode_d = MODE_RIGHT;
        k_d     = '0;
        peak_d  = 1'b0;
        sum_d   = '0;
        div_d   = '0;
        state_d = B_WALK;
      end
      B_WALK: begin
        peak_d = peak_n;
        if (!stop) begin
          sum_d = sum_q + SUM_W'(term);
          div_d = div_q + DIVR_W'(rd_data_i);
        end
        k_d = k_q + SIDX_W'(1);
        if (stop || k_q == SIDX_W'(NUM_SENSORS - 1)) begin
          state_d = B_DSTART;
        end
      end
      B_DSTART: begin
        dvd_d  = sum_q;
        rem_d  = '0;
        dcnt_d = '0;
        if (div_q == '0) begin
          center_d = '0;
          state_d  = B_PD;
        end else begin
          state_d  = B_DIV;
        end
      end
      B_DIV: begin
        rem_d  = ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
        dvd_d  = dvd_n;
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
          center_d = CEN_W'(dvd_n);
          state_d  = B_PD;
        end
      end
      B_PD: begin
        lost_d  = (center_q == '0);
        prop_d  = prop_n;
        deriv_d = 17'(prop_n) - 17'(prev_q);
        prev_d  = prop_n;
        state_d = B_MULP;
      end
      B_MULP: begin
        prod_d  = prop_q * $signed(cfg_i.gain_p);
        state_d = B_MULD;
      end
      B_MULD: begin
        acc_d   = ACC_W'(prod_q) + ACC_W'(dprod);
        state_d = B_DRIVE;
      end
      B_DRIVE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          if (cfg_i.safety_mode && trans_q == 4'd0) begin
            ld_d = cfg_i.max_speed;
            rd_d = cfg_i.max_speed;
          end else begin
            ld_d = clamp(lv, floor_v, cfg_i.max_speed);
            rd_d = clamp(rv, floor_v, cfg_i.max_speed);
          end
          tm_d    = mode_q;
          lo_d    = lost_q;
          to_d    = trans_q;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      vc_q    <= '0;
      vl_q    <= '0;
      vr_q    <= '0;
      mode_q  <= MODE_CENTRE;
      prev_q  <= '0;
      ov_q    <= 1'b0;
      k_q     <= '0;
      dcnt_q  <= '0;
      peak_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vc_q    <= vc_d;
      vl_q    <= vl_d;
      vr_q    <= vr_d;
      mode_q  <= mode_d;
      prev_q  <= prev_d;
      ov_q    <= ov_d;
      k_q     <= k_d;
      dcnt_q  <= dcnt_d;
      peak_q  <= peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mark_q   <= mark_d;
    trans_q  <= trans_d;
    sum_q    <= sum_d;
    div_q    <= div_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    center_q <= center_d;
    prop_q   <= prop_d;
    deriv_q  <= deriv_d;
    lost_q   <= lost_d;
    prod_q   <= prod_d;
    acc_q    <= acc_d;
    ld_q     <= ld_d;
    rd_q     <= rd_d;
    tm_q     <= tm_d;
    lo_q     <= lo_d;
    to_q     <= to_d;
  end

  assign out_valid_o   = ov_q;
  assign left_drive_o  = ld_q;
  assign right_drive_o = rd_q;
  assign track_mode_o  = tm_q;
  assign line_lost_o   = lo_q;
  assign transitions_o = to_q;

endmodule
`default_nettype wire

FILE: hw/rtl/line_follow_pd_steering.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_pd_steering: centroid line follower with PD steering
// Front stores one frame of samples; back votes, finds the line, runs PD.
//
//   channel   handshake                 payload
//   in        in_valid_i / in_stall_o   front_value_i, mark_pattern_i, frame_end_i
//   out       out_valid_o / out_stall_i left/right_drive_o, track_mode_o,
//                                       line_lost_o, transitions_o
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One sample per cycle is taken while the back end is idle.
// The back end evaluates a frame with the one-sample-per-cycle centroid walk and
// the bit-serial divider.
// Input stalls from frame end until the back end has loaded its result.
// Reset clears votes, mode, previous error and the sample count.
// ----------------------------------------------------------------------------
module line_follow_pd_steering import lfpd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [SMP_W-1:0] front_value_i,
  input  logic [PAT_W-1:0] mark_pattern_i,
  input  logic             frame_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DRV_W-1:0] left_drive_o,
  output logic [DRV_W-1:0] right_drive_o,
  output logic [1:0]       track_mode_o,
  output logic             line_lost_o,
  output logic [3:0]       transitions_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  cfg_t             cfg_q, cfg_d;
  job_t             job;
  back_ctl_t        ctl;
  logic [SMP_W-1:0] rd_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_SPEED: cfg_d.max_speed       = cfg_data_i[11:0];
        CFG_CRUISE:    cfg_d.cruise_speed    = cfg_data_i[11:0];
        CFG_SETPOINT:  cfg_d.center_setpoint = cfg_data_i[13:0];
        CFG_VOTE_LIM:  cfg_d.vote_limit      = cfg_data_i[7:0];
        CFG_GAIN_P:    cfg_d.gain_p          = cfg_data_i;
        CFG_GAIN_D:    cfg_d.gain_d          = cfg_data_i;
        CFG_SAFETY:    cfg_d.safety_mode     = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_speed: 12'd4095, cruise_speed: 12'd3000,
                 center_setpoint: 14'd6500, vote_limit: 8'd10,
                 gain_p: 16'd64, gain_d: 16'd77, safety_mode: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  lfpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .front_value_i  (front_value_i),
    .mark_pattern_i (mark_pattern_i),
    .frame_end_i    (frame_end_i),
    .ctl_i          (ctl),
    .job_o          (job),
    .rd_data_o      (rd_data)
  );

  lfpd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .job_i         (job),
    .ctl_o         (ctl),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .track_mode_o  (track_mode_o),
    .line_lost_o   (line_lost_o),
    .transitions_o (transitions_o)
  );

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.busy |-> in_stall_o) else $error("input taken while back end busy");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.pop |=> ctl.busy) else $error("job popped without starting");
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> track_mode_o != 2'd3) else $error("bad track mode");
  a_drive_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_drive_o <= cfg_q.max_speed && right_drive_o <= cfg_q.max_speed))
    else $error("drive above max speed");
`endif

endmodule
`default_nettype wire

FILE: test/line_follow_pd_steering_tb.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steering_tb: self-checking bench for the PD steering block
// Drives sensor frames with random gaps, predicts votes, mode, centroid and
// PD drives per frame end, and compares each result on the result channel.
// ----------------------------------------------------------------------------
module line_follow_pd_steering_tb;
  import lfpd_pkg::*;

  typedef struct packed {
    logic [SMP_W-1:0] fv;
    logic [PAT_W-1:0] mark;
    logic             fend;
  } smp_req_t;

  typedef struct packed {
    logic [DRV_W-1:0] ld;
    logic [DRV_W-1:0] rd;
    logic [1:0]       mode;
    logic             lost;
    logic [3:0]       trans;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [SMP_W-1:0] front_value_i = '0;
  logic [PAT_W-1:0] mark_pattern_i = '0;
  logic frame_end_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [DRV_W-1:0] left_drive_o, right_drive_o;
  logic [1:0] track_mode_o;
  logic line_lost_o;
  logic [3:0] transitions_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  line_follow_pd_steering u_top (.*);

  always #5 clk_i = ~clk_i;

  // steering model state
  int unsigned max_spd, cruise, setpt, vlim, safety;
  int gp, gd;
  int unsigned store [NUM_SENSORS];
  int unsigned sidx, v_c, v_l, v_r, mark_q;
  mode_e mode_q;
  int prev_err;

  smp_req_t sample_q[$];
  drive_t   drive_q[$];
  int errors = 0;
  int hold_off = 0;
  bit hold_req = 0;
  bit hold_long = 0;
  longint cycles = 0;

  function automatic int unsigned vote_up(int unsigned v);
    return (v <= vlim && v < 255) ? v + 1 : v;
  endfunction

  function automatic int unsigned vote_dn(int unsigned v);
    return v > 0 ? v - 1 : 0;
  endfunction

  function automatic void steer_step(smp_req_t s);
    int unsigned tr, wr, wl, cen, k, i;
    bit c, l, r, pk;
    longint sum, dv, acc, corr, flr, x, top;
    int prop, der;
    drive_t d;
    if (sidx == 0) mark_q = s.mark;
    if (sidx < NUM_SENSORS) begin
      store[sidx] = s.fv;
      sidx++;
    end
    if (!s.fend) return;
    sidx = 0;
    tr = 0; wr = 0; wl = 0; c = 0; l = 0; r = 0;
    for (i = 1; i < MARK_SENSORS; i++)
      if (mark_q[i] != mark_q[i-1]) tr++;
    while (wr < MARK_SENSORS && !mark_q[MARK_SENSORS-1-wr]) wr++;
    while (wl < MARK_SENSORS && !mark_q[wl]) wl++;
    if (tr == 3) begin
      if (wr > 0) l = 1; else r = 1;
    end else if (tr == 4) begin
      if (wr > 0) begin
        if (wr > wl + 1) l = 1;
        else if (wl > wr + 1) r = 1;
      end else c = 1;
    end else if (tr >= 5 && tr <= 7) c = 1;
    if (c) begin
      v_c = vote_up(v_c); v_l = vote_dn(v_l); v_r = vote_dn(v_r);
    end
    if (l) begin
      v_l = vote_up(v_l); v_c = vote_dn(v_c); v_r = vote_dn(v_r);
    end
    if (r) begin
      v_r = vote_up(v_r); v_c = vote_dn(v_c); v_l = vote_dn(v_l);
    end
    if (v_c > v_l && v_c > v_r) mode_q = MODE_CENTRE;
    else if (v_l > v_r) mode_q = MODE_LEFT;
    else if (v_l < v_r) mode_q = MODE_RIGHT;
    sum = 0; dv = 0; pk = 0;
    for (k = 0; k < NUM_SENSORS; k++) begin
      i = (mode_q == MODE_RIGHT) ? NUM_SENSORS - 1 - k : k;
      if (mode_q != MODE_CENTRE) begin
        if (store[i] > 0) pk = 1;
        if (pk && store[i] == 0) break;
      end
      sum += longint'(POS_WEIGHT) * (i + 1) * store[i];
      dv += store[i];
    end
    cen = dv > 0 ? sum / dv : 0;
    d.lost = (cen == 0);
    prop = d.lost ? prev_err : int'(cen) - int'(setpt);
    der = prop - prev_err;
    prev_err = prop;
    acc = longint'(prop) * gp + longint'(der) * gd;
    corr = acc < 0 ? -((-acc) / 256) : acc / 256;
    top = longint'(max_spd);
    flr = top - longint'(cruise);
    if (flr < 0) flr = 0;
    if (safety && tr == 0) begin
      d.ld = max_spd; d.rd = max_spd;
    end else begin
      x = flr - corr;
      d.ld = x > top ? top : (x < flr ? flr : x);
      x = flr + corr;
      d.rd = x > top ? top : (x < flr ? flr : x);
    end
    d.mode = mode_q;
    d.trans = tr;
    drive_q.push_back(d);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // driver
  int gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) steer_step({front_value_i, mark_pattern_i, frame_end_i});
      if (!in_valid_i || !in_stall_o) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() > 0) begin
          smp_req_t s;
          s = sample_q.pop_front();
          in_valid_i <= 1'b1;
          front_value_i <= s.fv;
          mark_pattern_i <= s.mark;
          frame_end_i <= s.fend;
          gap <= ($urandom_range(0, 3) == 0) ?
                 (($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3))
                 : 0;
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          $display("%0t: unexpected result ld=%0d rd=%0d", $time, left_drive_o, right_drive_o);
          errors++;
        end else begin
          drive_t e;
          e = drive_q.pop_front();
          if (e.ld !== left_drive_o) begin
            $display("%0t: left_drive exp %0d got %0d", $time, e.ld, left_drive_o); errors++;
          end
          if (e.rd !== right_drive_o) begin
            $display("%0t: right_drive exp %0d got %0d", $time, e.rd, right_drive_o); errors++;
          end
          if (e.mode !== track_mode_o) begin
            $display("%0t: track_mode exp %0d got %0d", $time, e.mode, track_mode_o); errors++;
          end
          if (e.lost !== line_lost_o) begin
            $display("%0t: line_lost exp %0d got %0d", $time, e.lost, line_lost_o); errors++;
          end
          if (e.trans !== transitions_o) begin
            $display("%0t: transitions exp %0d got %0d", $time, e.trans, transitions_o);
            errors++;
          end
        end
      end
      if (hold_long) begin
        out_stall_i <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        if ($urandom_range(0, 30) == 0) hold_off <= $urandom_range(10, 60);
      end else out_stall_i <= 1'b0;
    end
  end

  task automatic reg_write(cfg_idx_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_SPEED: max_spd = val[11:0];
      CFG_CRUISE:    cruise = val[11:0];
      CFG_SETPOINT:  setpt = val[13:0];
      CFG_VOTE_LIM:  vlim = val[7:0];
      CFG_GAIN_P:    gp = $signed(val);
      CFG_GAIN_D:    gd = $signed(val);
      CFG_SAFETY:    safety = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_valid_i || drive_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [PAT_W-1:0] rand_mark();
    case ($urandom_range(0, 5))
      0: return 9'b000111000;
      1: return 9'b000000111 << $urandom_range(0, 6);
      2: return 9'b010101010;
      3: return 9'b110001011;
      default: return PAT_W'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] rand_smp(int pos, int peak);
    int dd;
    dd = pos > peak ? pos - peak : peak - pos;
    case ($urandom_range(0, 3))
      0: return SMP_W'($urandom_range(0, 1023));
      1: return '0;
      default: return SMP_W'(dd < 2 ? $urandom_range(200, 1023)
                                    : (dd < 3 ? $urandom_range(0, 50) : 0));
    endcase
  endfunction

  // push one frame of n samples; push_frames makes full frames dominate, a few short or overlong
  task automatic push_frame(int n, logic [PAT_W-1:0] m);
    int pk;
    smp_req_t s;
    pk = $urandom_range(0, NUM_SENSORS - 1);
    for (int i = 0; i < n; i++) begin
      s.fv = rand_smp(i, pk);
      s.mark = (i == 0) ? m : PAT_W'($urandom_range(0, 511));
      s.fend = (i == n - 1);
      sample_q.push_back(s);
    end
  endtask

  task automatic push_frames(int count);
    int n;
    for (int f = 0; f < count; f++) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, NUM_SENSORS + 4) : NUM_SENSORS;
      push_frame(n, rand_mark());
    end
  endtask

  initial begin
    smp_req_t s;
    max_spd = 4095; cruise = 3000; setpt = 6500; vlim = 10; gp = 64; gd = 77;
    safety = 0;
    foreach (store[i]) store[i] = 0;
    sidx = 0; v_c = 0; v_l = 0; v_r = 0; mark_q = 0; mode_q = MODE_CENTRE; prev_err = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, all-dark frame, overlong frame, single items
    for (int i = 0; i < NUM_SENSORS; i++) begin
      s.fv = (i % 2) ? 10'h3FF : 10'h000;
      s.mark = 9'h1FF; s.fend = (i == NUM_SENSORS - 1);
      sample_q.push_back(s);
    end
    for (int i = 0; i < NUM_SENSORS; i++) begin
      s.fv = 0; s.mark = 9'h000; s.fend = (i == NUM_SENSORS - 1);
      sample_q.push_back(s);
    end
    push_frame(NUM_SENSORS + 3, 9'b000111000);
    s.fv = 10'h3FF; s.mark = 9'b011100011; s.fend = 1; sample_q.push_back(s);
    s.fv = 10'h155; s.mark = 9'b100011100; s.fend = 1; sample_q.push_back(s);
    drain();
    reg_write(CFG_SAFETY, 16'd1);
    reg_write(CFG_VOTE_LIM, 16'd0);
    reg_write(CFG_GAIN_P, 16'h7FFF);
    reg_write(CFG_GAIN_D, 16'h8000);
    reg_write(CFG_SETPOINT, 16'h3FFF);
    push_frame(NUM_SENSORS, 9'h000);
    push_frames(10);
    hold_req = 1;
    drain();
    reg_write(CFG_MAX_SPEED, 16'd100);
    reg_write(CFG_CRUISE, 16'd4095);
    reg_write(CFG_VOTE_LIM, 16'd254);
    reg_write(CFG_SETPOINT, 16'd0);
    reg_write(CFG_GAIN_P, 16'hFF00);
    push_frames(18);
    drain();
    reg_write(CFG_MAX_SPEED, 16'd0);
    reg_write(CFG_CRUISE, 16'd0);
    reg_write(CFG_SAFETY, 16'd0);
    push_frames(8);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(CFG_MAX_SPEED, 16'($urandom_range(0, 4095)));
      reg_write(CFG_CRUISE, 16'($urandom_range(0, 4095)));
      reg_write(CFG_SETPOINT, 16'($urandom_range(0, 16383)));
      reg_write(CFG_VOTE_LIM, 16'($urandom_range(0, 12)));
      reg_write(CFG_GAIN_P, 16'($urandom_range(0, 65535)));
      reg_write(CFG_GAIN_D, 16'($urandom_range(0, 65535)));
      reg_write(CFG_SAFETY, 16'($urandom_range(0, 1)));
      push_frames(12);
      drain();
    end
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
